FILE: rtl/core/hkrcd_pkg.sv
// Shared types, constants and helpers for the keyboard report change detector.
package hkrcd_pkg;

    localparam int IN_SLOTS      = 6;
    localparam int KEY_SLOTS_DEF = 6;
    localparam int KEY_W         = 8;
    localparam int MOD_W         = 8;
    localparam int TMO_W         = 16;
    localparam int CODE_W        = 3;

    localparam logic [TMO_W-1:0] TMO_RESET = 16'd100;
    localparam logic [TMO_W-1:0] IDLE_MAX  = 16'hFFFF;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [MOD_W-1:0] t_mod;

    typedef enum logic [CODE_W-1:0] {
        EV_PRESS       = 3'd0,
        EV_RELEASE     = 3'd1,
        EV_MOD_DOWN    = 3'd2,
        EV_MOD_UP      = 3'd3,
        EV_RELEASE_ALL = 3'd4
    } t_ev_code;

    typedef enum logic {
        KIND_REPORT = 1'b0,
        KIND_TICK   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic idle;
        logic load;
        logic eval;
        logic emit;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic pend_any;
        logic pend_last;
        logic out_free;
    } t_sts;

    // Letters, digits, space and punctuation; everything else nonzero is special.
    function automatic logic is_printing(input t_key k);
        logic r;
        r = ((k >= 8'h04) && (k <= 8'h27)) ||
            ((k >= 8'h2C) && (k <= 8'h31)) ||
            ((k >= 8'h33) && (k <= 8'h38));
        return r;
    endfunction

endpackage

FILE: rtl/core/hkrcd_if.sv
// Channel interfaces: report/tick input, event output and timeout register write.
interface hkrcd_in_if;
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [7:0]             modifier_bits;
    logic [7:0]             key_slot0;
    logic [7:0]             key_slot1;
    logic [7:0]             key_slot2;
    logic [7:0]             key_slot3;
    logic [7:0]             key_slot4;
    logic [7:0]             key_slot5;

    modport source (
        output valid, kind, modifier_bits,
               key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5,
        input  ready
    );
    modport sink (
        input  valid, kind, modifier_bits,
               key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5,
        output ready
    );
endinterface

interface hkrcd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [7:0] event_key;
    logic [7:0] event_modifier;
    logic       is_special;
    logic       last_event;

    modport source (
        output valid, event_code, event_key, event_modifier, is_special, last_event,
        input  ready
    );
    modport sink (
        input  valid, event_code, event_key, event_modifier, is_special, last_event,
        output ready
    );
endinterface

interface hkrcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/hkrcd_ctrl.sv
// Sequencer: accept a request, evaluate, emit events one per cycle unless stalled, commit state.
module hkrcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hkrcd_pkg::t_sts i_sts,
    output hkrcd_pkg::t_cmd o_cmd
);

    hkrcd_pkg::t_state r_state;
    hkrcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkrcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            hkrcd_pkg::ST_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = hkrcd_pkg::ST_EVAL;
                end
            end
            hkrcd_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = hkrcd_pkg::ST_EMIT;
            end
            hkrcd_pkg::ST_EMIT: begin
                if (!i_sts.pend_any) begin
                    n_state = hkrcd_pkg::ST_COMMIT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.pend_last) begin
                        n_state = hkrcd_pkg::ST_COMMIT;
                    end
                end
            end
            hkrcd_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = hkrcd_pkg::ST_IDLE;
            end
            default: begin
                n_state = hkrcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/hkrcd_dp.sv
// Datapath: stored report, event pending mask, idle timer and event output register.
module hkrcd_dp #(
    parameter int KEY_SLOTS = hkrcd_pkg::KEY_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hkrcd_pkg::t_cmd              i_cmd,
    output hkrcd_pkg::t_sts              o_sts,
    input  logic                         i_in_valid,
    input  logic                         i_kind,
    input  hkrcd_pkg::t_mod              i_mod,
    input  hkrcd_pkg::t_key              i_keys [hkrcd_pkg::IN_SLOTS],
    input  logic                         i_cfg_we,
    input  logic [hkrcd_pkg::TMO_W-1:0]  i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [hkrcd_pkg::CODE_W-1:0] o_event_code,
    output hkrcd_pkg::t_key              o_event_key,
    output hkrcd_pkg::t_mod              o_event_modifier,
    output logic                         o_is_special,
    output logic                         o_last_event
);

    localparam int USED = (KEY_SLOTS < hkrcd_pkg::IN_SLOTS) ? KEY_SLOTS : hkrcd_pkg::IN_SLOTS;
    // pending bits: presses, releases, modifier down, modifier up, release all
    localparam int NEV    = 2 * USED + 3;
    localparam int B_DOWN = 2 * USED;
    localparam int B_UP   = 2 * USED + 1;
    localparam int B_RALL = 2 * USED + 2;

    logic                        r_kind;
    hkrcd_pkg::t_mod             r_mod;
    hkrcd_pkg::t_key             r_cur  [USED];
    hkrcd_pkg::t_key             r_prev [USED];
    hkrcd_pkg::t_mod             r_prev_mod;
    logic                        r_held;
    logic [hkrcd_pkg::TMO_W-1:0] r_idle;
    logic [hkrcd_pkg::TMO_W-1:0] r_tmo;
    logic [NEV-1:0]              r_pend;
    logic                        r_fire;

    logic                        r_out_valid;
    logic [hkrcd_pkg::CODE_W-1:0] r_out_code;
    hkrcd_pkg::t_key             r_out_key;
    hkrcd_pkg::t_mod             r_out_mod;
    logic                        r_out_special;
    logic                        r_out_last;

    logic [NEV-1:0]              n_pend;
    logic [hkrcd_pkg::TMO_W-1:0] w_idle_nxt;
    logic                        w_fire;
    logic                        w_any;
    logic [NEV-1:0]              w_low;
    logic [NEV-1:0]              w_rest;
    hkrcd_pkg::t_ev_code         w_code;
    hkrcd_pkg::t_key             w_key;
    hkrcd_pkg::t_mod             w_emod;
    logic                        w_special;

    assign w_idle_nxt = (r_idle == hkrcd_pkg::IDLE_MAX) ? r_idle
                                                        : r_idle + hkrcd_pkg::TMO_W'(1);
    assign w_fire     = r_held && (w_idle_nxt > r_tmo);

    // Compare every slot against every stored slot in parallel.
    always_comb begin
        logic hit_prev;
        logic hit_cur;
        n_pend = '0;
        w_any  = (r_mod != '0);
        for (int i = 0; i < USED; i++) begin
            hit_prev = 1'b0;
            hit_cur  = 1'b0;
            for (int j = 0; j < USED; j++) begin
                hit_prev = hit_prev | (r_prev[j] == r_cur[i]);
                hit_cur  = hit_cur  | (r_cur[j]  == r_prev[i]);
            end
            n_pend[i]        = (r_cur[i]  != '0) && !hit_prev;
            n_pend[USED + i] = (r_prev[i] != '0) && !hit_cur;
            w_any            = w_any | (r_cur[i] != '0);
        end
        n_pend[B_DOWN] = |(r_mod & ~r_prev_mod);
        n_pend[B_UP]   = |(r_prev_mod & ~r_mod);
        n_pend[B_RALL] = 1'b0;
        if (r_kind == hkrcd_pkg::KIND_TICK) begin
            n_pend         = '0;
            n_pend[B_RALL] = w_fire;
        end
    end

    // Take the lowest pending event.
    assign w_low  = r_pend & (~r_pend + NEV'(1));
    assign w_rest = r_pend & ~w_low;

    always_comb begin
        w_key     = '0;
        w_special = 1'b0;
        for (int i = 0; i < USED; i++) begin
            if (w_low[i]) begin
                w_key     = w_key | r_cur[i];
                w_special = w_special | !hkrcd_pkg::is_printing(r_cur[i]);
            end
            if (w_low[USED + i]) begin
                w_key = w_key | r_prev[i];
            end
        end
        priority if (w_low[B_RALL]) begin
            w_code = hkrcd_pkg::EV_RELEASE_ALL;
            w_emod = '0;
        end else if (w_low[B_UP]) begin
            w_code = hkrcd_pkg::EV_MOD_UP;
            w_emod = r_prev_mod;
        end else if (w_low[B_DOWN]) begin
            w_code = hkrcd_pkg::EV_MOD_DOWN;
            w_emod = r_mod;
        end else if (|w_low[2*USED-1:USED]) begin
            w_code = hkrcd_pkg::EV_RELEASE;
            w_emod = r_prev_mod;
        end else begin
            w_code = hkrcd_pkg::EV_PRESS;
            w_emod = r_mod;
        end
    end

    // Request payload, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_mod  <= i_mod;
            for (int i = 0; i < USED; i++) begin
                r_cur[i] <= i_keys[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_fire <= 1'b0;
        end else if (i_cmd.eval) begin
            r_pend <= n_pend;
            r_fire <= (r_kind == hkrcd_pkg::KIND_TICK) && w_fire;
        end else if (i_cmd.emit) begin
            r_pend <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo <= hkrcd_pkg::TMO_RESET;
        end else if (i_cfg_we) begin
            r_tmo <= i_cfg_data;
        end
    end

    // Update stored report and timer once all events are out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < USED; i++) begin
                r_prev[i] <= '0;
            end
            r_prev_mod <= '0;
            r_held     <= 1'b0;
            r_idle     <= '0;
        end else if (i_cmd.commit) begin
            if (r_kind == hkrcd_pkg::KIND_REPORT) begin
                for (int i = 0; i < USED; i++) begin
                    r_prev[i] <= r_cur[i];
                end
                r_prev_mod <= r_mod;
                r_held     <= w_any;
                r_idle     <= '0;
            end else begin
                r_idle <= w_idle_nxt;
                if (r_fire) begin
                    for (int i = 0; i < USED; i++) begin
                        r_prev[i] <= '0;
                    end
                    r_prev_mod <= '0;
                    r_held     <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_code    <= w_code;
            r_out_key     <= w_key;
            r_out_mod     <= w_emod;
            r_out_special <= w_special;
            r_out_last    <= (w_rest == '0);
        end
    end

    assign o_sts.in_valid  = i_in_valid;
    assign o_sts.pend_any  = |r_pend;
    assign o_sts.pend_last = (w_rest == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_event_code     = r_out_code;
    assign o_event_key      = r_out_key;
    assign o_event_modifier = r_out_mod;
    assign o_is_special     = r_out_special;
    assign o_last_event     = r_out_last;

endmodule

FILE: rtl/core/hid_key_report_change_detector_core.sv
// Top level of the keyboard report change detector: sequencer, datapath and checks.
// Each request is a boot keyboard report or a one millisecond tick. A report is compared
// with the stored one and yields press events (new nonzero keys, in slot order), release
// events (stored keys now gone), then modifier down and modifier up; a tick yields one
// release-all once keys have been held with no report for longer than the timeout.
// Events leave one per cycle while the output is not stalled, through a single output
// register, the last one of a request flagged by last_event. A request yields up to
// 2*min(KEY_SLOTS, 6) + 2 events, so 14 at most; a request is taken only in the idle
// state, while an earlier event may still wait in the output register. The timeout
// register is written through the config channel, which is always ready, and should
// only be written while no request is in progress.
module hid_key_report_change_detector_core #(
    parameter int KEY_SLOTS = hkrcd_pkg::KEY_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hkrcd_in_if.sink     i_in,
    hkrcd_out_if.source  o_out,
    hkrcd_cfg_if.sink    i_cfg
);

    hkrcd_pkg::t_cmd w_cmd;
    hkrcd_pkg::t_sts w_sts;
    hkrcd_pkg::t_key w_keys [hkrcd_pkg::IN_SLOTS];

    assign w_keys[0] = i_in.key_slot0;
    assign w_keys[1] = i_in.key_slot1;
    assign w_keys[2] = i_in.key_slot2;
    assign w_keys[3] = i_in.key_slot3;
    assign w_keys[4] = i_in.key_slot4;
    assign w_keys[5] = i_in.key_slot5;

    assign i_in.ready  = w_cmd.idle;
    assign i_cfg.ready = 1'b1;

    hkrcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    hkrcd_dp #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_in_valid       (i_in.valid),
        .i_kind           (i_in.kind),
        .i_mod            (i_in.modifier_bits),
        .i_keys           (w_keys),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_event_code     (o_out.event_code),
        .o_event_key      (o_out.event_key),
        .o_event_modifier (o_out.event_modifier),
        .o_is_special     (o_out.is_special),
        .o_last_event     (o_out.last_event)
    );

    // A request is evaluated before the next one is taken.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready
    ) else $error("request accepted while previous one still in progress");

    // An event is issued only when one is pending and the output register can take it.
    a_emit_legal: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (w_sts.pend_any && w_sts.out_free)
    ) else $error("event issued with nothing pending or output full");

    // Issued event shows up at the output register next cycle.
    a_emit_visible: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out.valid
    ) else $error("issued event not held in output register");

    // After commit the block is idle again.
    a_commit_to_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> i_in.ready
    ) else $error("block not idle after commit");

endmodule

FILE: sim/tb_hid_key_report_change_detector_core.sv
// Self-checking testbench for the keyboard report change detector core.
module tb_hid_key_report_change_detector_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACTIVE_SLOTS = (hkrcd_pkg::KEY_SLOTS_DEF < hkrcd_pkg::IN_SLOTS) ?
                                  hkrcd_pkg::KEY_SLOTS_DEF : hkrcd_pkg::IN_SLOTS;
    localparam int SETTLE_CYCLES = 24;

    typedef logic [hkrcd_pkg::IN_SLOTS-1:0][hkrcd_pkg::KEY_W-1:0] t_slots;

    typedef struct packed {
        logic              kind;
        hkrcd_pkg::t_mod   modv;
        t_slots            keys;
    } t_report_req;

    typedef struct packed {
        logic [hkrcd_pkg::CODE_W-1:0] code;
        hkrcd_pkg::t_key              key;
        hkrcd_pkg::t_mod              modv;
        logic                         special;
        logic                         is_last;
    } t_key_event;

    class key_event_scoreboard;
        t_slots                      prev_keys;
        hkrcd_pkg::t_mod             prev_mod;
        bit                          keys_held;
        logic [hkrcd_pkg::TMO_W-1:0] idle_ms;
        logic [hkrcd_pkg::TMO_W-1:0] timeout_ms;
        t_key_event                  expected_events [$];
        int                          errors;
        int                          n_reports;
        int                          n_ticks;
        int                          code_count [5];

        function new();
            prev_keys  = '0;
            prev_mod   = '0;
            keys_held  = 1'b0;
            idle_ms    = '0;
            timeout_ms = hkrcd_pkg::TMO_RESET;
            errors     = 0;
            n_reports  = 0;
            n_ticks    = 0;
            foreach (code_count[i]) code_count[i] = 0;
        endfunction

        function bit is_text_key(hkrcd_pkg::t_key k);
            return (k >= 8'h04 && k <= 8'h27) || (k >= 8'h2C && k <= 8'h31) ||
                   (k >= 8'h33 && k <= 8'h38);
        endfunction

        function bit seen_in(hkrcd_pkg::t_key k, t_slots s);
            for (int i = 0; i < ACTIVE_SLOTS; i++)
                if (s[i] == k) return 1'b1;
            return 1'b0;
        endfunction

        function t_key_event make_event(hkrcd_pkg::t_ev_code c, hkrcd_pkg::t_key k,
                                        hkrcd_pkg::t_mod m, logic sp);
            t_key_event e;
            e.code    = c;
            e.key     = k;
            e.modv    = m;
            e.special = sp;
            e.is_last = 1'b0;
            return e;
        endfunction

        // Work out the events one accepted request causes and advance the state.
        function void note_request(t_report_req r);
            t_key_event      evs [$];
            t_slots          cur;
            hkrcd_pkg::t_mod down;
            hkrcd_pkg::t_mod up;
            bit              any;
            cur = '0;
            if (r.kind == hkrcd_pkg::KIND_REPORT) begin
                n_reports++;
                for (int i = 0; i < ACTIVE_SLOTS; i++) cur[i] = r.keys[i];
                for (int i = 0; i < ACTIVE_SLOTS; i++)
                    if (cur[i] != 0 && !seen_in(cur[i], prev_keys))
                        evs.push_back(make_event(hkrcd_pkg::EV_PRESS, cur[i], r.modv,
                                                 !is_text_key(cur[i])));
                for (int i = 0; i < ACTIVE_SLOTS; i++)
                    if (prev_keys[i] != 0 && !seen_in(prev_keys[i], cur))
                        evs.push_back(make_event(hkrcd_pkg::EV_RELEASE, prev_keys[i],
                                                 prev_mod, 1'b0));
                down = r.modv & ~prev_mod;
                up   = prev_mod & ~r.modv;
                if (down != 0)
                    evs.push_back(make_event(hkrcd_pkg::EV_MOD_DOWN, '0, r.modv, 1'b0));
                if (up != 0)
                    evs.push_back(make_event(hkrcd_pkg::EV_MOD_UP, '0, prev_mod, 1'b0));
                any = (r.modv != 0) || (cur != '0);
                keys_held = any;
                prev_keys = cur;
                prev_mod  = r.modv;
                idle_ms   = '0;
            end else begin
                n_ticks++;
                if (idle_ms != hkrcd_pkg::IDLE_MAX) idle_ms++;
                if (keys_held && idle_ms > timeout_ms) begin
                    evs.push_back(make_event(hkrcd_pkg::EV_RELEASE_ALL, '0, '0, 1'b0));
                    keys_held = 1'b0;
                    prev_keys = '0;
                    prev_mod  = '0;
                end
            end
            if (evs.size() > 0) evs[evs.size()-1].is_last = 1'b1;
            foreach (evs[i]) expected_events.push_back(evs[i]);
        endfunction

        function void check_event(t_key_event got);
            t_key_event want;
            if (expected_events.size() == 0) begin
                $error("event with nothing expected: code %0d key %02h", got.code, got.key);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (want.code < 5) code_count[want.code]++;
            if (got.code !== want.code) begin
                $error("event_code: expected %0d, actual %0d", want.code, got.code);
                errors++;
            end
            if (got.key !== want.key) begin
                $error("event_key: expected %02h, actual %02h", want.key, got.key);
                errors++;
            end
            if (got.modv !== want.modv) begin
                $error("event_modifier: expected %02h, actual %02h", want.modv, got.modv);
                errors++;
            end
            if (got.special !== want.special) begin
                $error("is_special: expected %0b, actual %0b", want.special, got.special);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("last_event: expected %0b, actual %0b", want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic evt_ready = 1'b0;
    bit   calm = 1'b0;

    t_slots                      sent_keys = '0;
    hkrcd_pkg::t_mod             sent_mod  = '0;
    logic [hkrcd_pkg::TMO_W-1:0] cur_timeout = hkrcd_pkg::TMO_RESET;

    key_event_scoreboard board = new();

    hkrcd_in_if  in_ch ();
    hkrcd_out_if out_ch ();
    hkrcd_cfg_if cfg_ch ();

    assign out_ch.ready = evt_ready;

    hid_key_report_change_detector_core #(
        .KEY_SLOTS(hkrcd_pkg::KEY_SLOTS_DEF)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the event side now and then, never while calm.
    always @(posedge i_clk) begin
        evt_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge i_clk) begin
        t_key_event  got;
        t_report_req req;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.code    = out_ch.event_code;
            got.key     = out_ch.event_key;
            got.modv    = out_ch.event_modifier;
            got.special = out_ch.is_special;
            got.is_last = out_ch.last_event;
            board.check_event(got);
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            req.kind = in_ch.kind;
            req.modv = in_ch.modifier_bits;
            req.keys = {in_ch.key_slot5, in_ch.key_slot4, in_ch.key_slot3,
                        in_ch.key_slot2, in_ch.key_slot1, in_ch.key_slot0};
            board.note_request(req);
        end
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) board.timeout_ms = cfg_ch.data;
    end

    task automatic send_req(t_report_req r);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 11) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= r.kind;
        in_ch.modifier_bits <= r.modv;
        in_ch.key_slot0     <= r.keys[0];
        in_ch.key_slot1     <= r.keys[1];
        in_ch.key_slot2     <= r.keys[2];
        in_ch.key_slot3     <= r.keys[3];
        in_ch.key_slot4     <= r.keys[4];
        in_ch.key_slot5     <= r.keys[5];
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Key slots are listed slot 5 first.
    task automatic send_report(hkrcd_pkg::t_mod m, t_slots k);
        t_report_req r;
        r.kind = hkrcd_pkg::KIND_REPORT;
        r.modv = m;
        r.keys = k;
        sent_mod  = m;
        sent_keys = k;
        send_req(r);
    endtask

    // Payload of a tick is ignored by the block; toggle it anyway.
    task automatic send_tick();
        t_report_req r;
        r.kind = hkrcd_pkg::KIND_TICK;
        r.modv = hkrcd_pkg::t_mod'($urandom_range(0, 255));
        for (int i = 0; i < hkrcd_pkg::IN_SLOTS; i++)
            r.keys[i] = hkrcd_pkg::t_key'($urandom_range(0, 255));
        send_req(r);
    endtask

    // Drop the request line and hold until every expected event is out.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_events.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [hkrcd_pkg::TMO_W-1:0] v);
        settle_block();
        cur_timeout  = v;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic hkrcd_pkg::t_mod pick_mod();
        case ($urandom_range(0, 3))
            0: return sent_mod;
            1: return sent_mod ^ (8'h01 << $urandom_range(0, 7));
            2: return hkrcd_pkg::t_mod'($urandom_range(0, 255));
            default: return '0;
        endcase
    endfunction

    // Favor keys still held so that most reports differ only a little.
    function automatic hkrcd_pkg::t_key pick_key(int slot);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sent_keys[slot];
            4: return sent_keys[$urandom_range(0, hkrcd_pkg::IN_SLOTS-1)];
            5: return '0;
            6, 7: return hkrcd_pkg::t_key'($urandom_range(8'h04, 8'h27));
            8: return hkrcd_pkg::t_key'($urandom_range(8'h26, 8'h3A));
            default: return hkrcd_pkg::t_key'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random(int budget);
        int     sent;
        int     burst;
        int     pick;
        t_slots k;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_report('0, '0);
                sent++;
            end else if (pick < 10) begin
                send_report(sent_mod, sent_keys);
                sent++;
            end else if (pick < 55) begin
                for (int i = 0; i < hkrcd_pkg::IN_SLOTS; i++) k[i] = pick_key(i);
                send_report(pick_mod(), k);
                sent++;
            end else begin
                // Now and then tick long enough to reach the timeout.
                if ($urandom_range(0, 3) == 0)
                    burst = int'(cur_timeout) + int'($urandom_range(0, 2));
                else
                    burst = int'($urandom_range(1, 3));
                if (burst > budget - sent) burst = budget - sent;
                repeat (burst) send_tick();
                sent += burst;
            end
        end
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.kind          = hkrcd_pkg::KIND_REPORT;
        in_ch.modifier_bits = '0;
        in_ch.key_slot0     = '0;
        in_ch.key_slot1     = '0;
        in_ch.key_slot2     = '0;
        in_ch.key_slot3     = '0;
        in_ch.key_slot4     = '0;
        in_ch.key_slot5     = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: printing bounds, special keys, full event load, repeats.
        send_report(8'h00, '0);
        send_report(8'h01, {8'h38, 8'h33, 8'h31, 8'h2C, 8'h27, 8'h04});
        send_report(8'h01, {8'h38, 8'h33, 8'h31, 8'h2C, 8'h27, 8'h04});
        send_report(8'h80, {8'hFF, 8'h39, 8'h32, 8'h2B, 8'h28, 8'h03});
        send_report(8'h80, {8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01});
        send_report(8'h00, '0);
        send_report(8'hFF, {8'h2D, 8'h00, 8'h00, 8'h30, 8'h00, 8'h2D});
        send_report(8'hFF, {8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE});
        send_tick();
        send_tick();
        send_report(8'h00, '0);

        // Release-all on a timeout of 1.
        write_timeout(16'd1);
        send_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1E});
        send_tick();
        send_tick();
        send_tick();
        send_report(8'h02, '0);
        send_tick();
        send_tick();
        send_report(8'h02, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
        send_report(8'h02, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
        send_tick();
        send_report(8'h02, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
        send_tick();

        write_timeout(16'd3);
        run_random(105);
        calm = 1'b1;
        write_timeout(16'd1);
        run_random(105);
        calm = 1'b0;
        write_timeout(16'($urandom_range(2, 8)));
        run_random(95);
        write_timeout(hkrcd_pkg::TMO_RESET);
        run_random(100);

        // The largest timeout holds the keys through a few ticks.
        calm = 1'b1;
        write_timeout(hkrcd_pkg::IDLE_MAX);
        send_report(8'h40, {8'h00, 8'h00, 8'h00, 8'h00, 8'h3A, 8'h15});
        repeat (4) send_tick();
        calm = 1'b0;

        settle_block();
        $display("Covered %0d reports and %0d ticks over timeouts from 1 to %0d.",
                 board.n_reports, board.n_ticks, hkrcd_pkg::IDLE_MAX);
        $display("Checked %0d presses, %0d releases, %0d modifier changes, %0d release-alls.",
                 board.code_count[hkrcd_pkg::EV_PRESS],
                 board.code_count[hkrcd_pkg::EV_RELEASE],
                 board.code_count[hkrcd_pkg::EV_MOD_DOWN] +
                 board.code_count[hkrcd_pkg::EV_MOD_UP],
                 board.code_count[hkrcd_pkg::EV_RELEASE_ALL]);
        if (board.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $error("run timed out with %0d events still expected", board.expected_events.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
